// File: hw/rtl/pdtg_pkg.sv
// ----------------------------------------------------------------------------
// Periodic decimal timestamp generator package
// Shared widths, character codes, limits and register indexes.
// ----------------------------------------------------------------------------
package pdtg_pkg;

  localparam int unsigned SecondsWidthDefault = 64;

  localparam int unsigned CfgDataWidth   = 64;
  localparam int unsigned CfgIdxWidth    = 3;
  localparam int unsigned IsecWidth      = 32;
  localparam int unsigned NsWidth        = 30;
  localparam int unsigned FdWidth        = 4;
  localparam int unsigned TickCountWidth = 64;
  localparam int unsigned CharWidth      = 8;

  // decimal conversion unit
  localparam int unsigned BinWidth     = 64;
  localparam int unsigned NumBcdDigits = 20;
  localparam int unsigned BcdWidth     = 4 * NumBcdDigits;
  localparam int unsigned FracDigits   = 9;

  localparam logic [NsWidth-1:0] NsMax  = NsWidth'(999999999);
  localparam logic [NsWidth:0]   NsPerS = (NsWidth + 1)'(1000000000);

  localparam logic [CharWidth-1:0] CharZero    = 8'h30;
  localparam logic [CharWidth-1:0] CharDot     = 8'h2e;
  localparam logic [CharWidth-1:0] CharNewline = 8'h0a;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgStartSeconds    = 3'd0,
    CfgIntervalSeconds = 3'd1,
    CfgIntervalNs      = 3'd2,
    CfgFractionDigits  = 3'd3,
    CfgKeepZeros       = 3'd4,
    CfgShowTickCount   = 3'd5,
    CfgTickLimit       = 3'd6
  } cfg_idx_e;

endpackage

// File: hw/rtl/pdtg_tick_if.sv
// ----------------------------------------------------------------------------
// Tick request channel
// Valid/ready channel carrying one timer expiry per request.
// ----------------------------------------------------------------------------
interface pdtg_tick_if;

  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);

endinterface

// File: hw/rtl/pdtg_char_if.sv
// ----------------------------------------------------------------------------
// Character request channel
// Valid/ready channel carrying one ASCII character of a timestamp line.
// ----------------------------------------------------------------------------
interface pdtg_char_if;
  import pdtg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] character;
  logic                 last_of_line;
  logic                 final_tick;

  modport source (output valid, output character, output last_of_line,
                  output final_tick, input ready);
  modport sink   (input valid, input character, input last_of_line,
                  input final_tick, output ready);

endinterface

// File: hw/rtl/periodic_decimal_timestamp_generator_top.sv
// ----------------------------------------------------------------------------
// Periodic decimal timestamp generator
// Per tick, streams the advanced time, or the tick count, as an ASCII line.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                  handshake
//  tick_i    in   tick                                     valid/ready
//  char_o    out  character, last_of_line, final_tick     valid/ready
//  cfg       in   cfg_idx_i, cfg_data_i                    cfg_we_i, no stall
//
//  A tick runs bookkeeping (limit check; outside count mode also the
//  nanosecond and seconds adds), 64 shared shift-add-3 steps, the skip of
//  leading zeros and the integer digits, then for a fraction 30 more steps,
//  a trim of dropped trailing zeros, the dot and its digits; the newline
//  ends the line. tick_i.ready is high only while idle; a stalled char_o
//  holds the sequencer. Reset loads all defaults.
// ----------------------------------------------------------------------------
module periodic_decimal_timestamp_generator_top #(
  parameter int unsigned SECONDS_WIDTH = pdtg_pkg::SecondsWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pdtg_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [pdtg_pkg::CfgDataWidth-1:0] cfg_data_i,
  pdtg_tick_if.sink                        tick_i,
  pdtg_char_if.source                      char_o
);
  import pdtg_pkg::*;

  localparam int unsigned CntWidth = $clog2(BinWidth + 1);

  typedef enum logic [3:0] {
    StIdle,
    StCheck,
    StNsAdd,
    StSecAdd,
    StConvI,
    StSkip,
    StEmitI,
    StConvF,
    StTrim,
    StDot,
    StEmitF,
    StNewline
  } state_e;

  state_e state_q;

  // configuration
  logic [IsecWidth-1:0]      isec_q;
  logic [NsWidth-1:0]        ins_q;     // held saturated
  logic [FdWidth-1:0]        fd_q;      // held saturated
  logic                      keep_q;
  logic                      show_q;
  logic [TickCountWidth-1:0] limit_q;

  // running state
  logic [SECONDS_WIDTH-1:0]  sec_q;
  logic [NsWidth-1:0]        ns_q;
  logic [TickCountWidth-1:0] ticks_q;
  logic                      stopped_q;
  logic                      fin_q;
  logic                      carry_q;

  // conversion unit
  logic [BinWidth-1:0] bin_q;
  logic [BcdWidth-1:0] bcd_q;
  logic [CntWidth-1:0] cnt_q;

  // output register
  logic                 ovalid_q;
  logic [CharWidth-1:0] ochar_q;
  logic                 olast_q;
  logic                 ofin_q;

  logic                     accept;
  logic                     slot_free;
  logic [NsWidth:0]         ns_sum_d;
  logic                     carry_d;
  logic [NsWidth-1:0]       ns_d;
  logic [SECONDS_WIDTH-1:0] sec_d;
  logic [BcdWidth-1:0]      bcd_adj;
  logic [BcdWidth-1:0]      bcd_step_d;
  logic [BinWidth-1:0]      bin_step_d;
  logic [FdWidth-1:0]       trim_idx;
  logic [3:0]               trim_digit;
  logic [FdWidth-1:0]       fd_sat_d;

  assign accept    = tick_i.valid && tick_i.ready;
  assign slot_free = !ovalid_q || char_o.ready;

  assign tick_i.ready        = (state_q == StIdle);
  assign char_o.valid        = ovalid_q;
  assign char_o.character    = ochar_q;
  assign char_o.last_of_line = olast_q;
  assign char_o.final_tick   = ofin_q;

  // nanosecond carry
  assign ns_sum_d = {1'b0, ns_q} + {1'b0, ins_q};
  assign carry_d  = ns_sum_d > {1'b0, NsMax};
  assign ns_d     = carry_d ? NsWidth'(ns_sum_d - NsPerS) : ns_sum_d[NsWidth-1:0];

  assign sec_d = sec_q + SECONDS_WIDTH'(isec_q) + SECONDS_WIDTH'(carry_q);

  // one shift-add-3 step over all BCD digits
  always_comb begin
    for (int i = 0; i < NumBcdDigits; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                       : bcd_q[4*i +: 4];
    end
    bcd_step_d = {bcd_adj[BcdWidth-2:0], bin_q[BinWidth-1]};
    bin_step_d = {bin_q[BinWidth-2:0], 1'b0};
  end

  // digit at fraction position cnt-1, counted from the left of nine
  assign trim_idx   = FdWidth'(FracDigits) - cnt_q[FdWidth-1:0];
  assign trim_digit = bcd_q[4*trim_idx +: 4];

  assign fd_sat_d = (cfg_data_i[FdWidth-1:0] > FdWidth'(FracDigits)) ?
                    FdWidth'(FracDigits) : cfg_data_i[FdWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      isec_q    <= IsecWidth'(1);
      ins_q     <= '0;
      fd_q      <= FdWidth'(FracDigits);
      keep_q    <= 1'b0;
      show_q    <= 1'b0;
      limit_q   <= '0;
      sec_q     <= '0;
      ns_q      <= '0;
      ticks_q   <= '0;
      stopped_q <= 1'b0;
      fin_q     <= 1'b0;
      carry_q   <= 1'b0;
      bin_q     <= '0;
      bcd_q     <= '0;
      cnt_q     <= '0;
      ovalid_q  <= 1'b0;
      ochar_q   <= '0;
      olast_q   <= 1'b0;
      ofin_q    <= 1'b0;
    end else begin
      if (char_o.ready) begin
        ovalid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartSeconds:    sec_q   <= cfg_data_i[SECONDS_WIDTH-1:0];
          CfgIntervalSeconds: isec_q  <= cfg_data_i[IsecWidth-1:0];
          CfgIntervalNs: begin
            ins_q <= (cfg_data_i[NsWidth-1:0] > NsMax) ? NsMax : cfg_data_i[NsWidth-1:0];
          end
          CfgFractionDigits:  fd_q    <= fd_sat_d;
          CfgKeepZeros:       keep_q  <= cfg_data_i[0];
          CfgShowTickCount:   show_q  <= cfg_data_i[0];
          CfgTickLimit:       limit_q <= cfg_data_i[TickCountWidth-1:0];
          default: ;
        endcase
      end

      case (state_q)
        StIdle: begin
          if (accept && tick_i.tick && !stopped_q) begin
            ticks_q <= ticks_q + TickCountWidth'(1);
            state_q <= StCheck;
          end
        end

        StCheck: begin
          fin_q <= (limit_q != '0) && (ticks_q == limit_q);
          if ((limit_q != '0) && (ticks_q == limit_q)) begin
            stopped_q <= 1'b1;
          end
          if (show_q) begin
            bin_q   <= BinWidth'(ticks_q);
            bcd_q   <= '0;
            cnt_q   <= CntWidth'(BinWidth);
            state_q <= StConvI;
          end else begin
            state_q <= StNsAdd;
          end
        end

        StNsAdd: begin
          if (ins_q != '0) begin
            ns_q    <= ns_d;
            carry_q <= carry_d;
          end else begin
            carry_q <= 1'b0;
          end
          state_q <= StSecAdd;
        end

        StSecAdd: begin
          sec_q   <= sec_d;
          bin_q   <= BinWidth'(sec_d);
          bcd_q   <= '0;
          cnt_q   <= CntWidth'(BinWidth);
          state_q <= StConvI;
        end

        StConvI: begin
          bcd_q <= bcd_step_d;
          bin_q <= bin_step_d;
          cnt_q <= cnt_q - CntWidth'(1);
          if (cnt_q == CntWidth'(1)) begin
            cnt_q   <= CntWidth'(NumBcdDigits);
            state_q <= StSkip;
          end
        end

        // drop leading zeros, keeping at least one digit
        StSkip: begin
          if (bcd_q[BcdWidth-1 -: 4] == 4'd0 && cnt_q > CntWidth'(1)) begin
            bcd_q <= {bcd_q[BcdWidth-5:0], 4'd0};
            cnt_q <= cnt_q - CntWidth'(1);
          end else begin
            state_q <= StEmitI;
          end
        end

        StEmitI: begin
          if (slot_free) begin
            ovalid_q <= 1'b1;
            ochar_q  <= CharZero + CharWidth'(bcd_q[BcdWidth-1 -: 4]);
            olast_q  <= 1'b0;
            ofin_q   <= fin_q;
            bcd_q    <= {bcd_q[BcdWidth-5:0], 4'd0};
            cnt_q    <= cnt_q - CntWidth'(1);
            if (cnt_q == CntWidth'(1)) begin
              if (show_q || ins_q == '0) begin
                state_q <= StNewline;
              end else begin
                bin_q   <= {ns_q, {(BinWidth - NsWidth){1'b0}}};
                bcd_q   <= '0;
                cnt_q   <= CntWidth'(NsWidth);
                state_q <= StConvF;
              end
            end
          end
        end

        StConvF: begin
          bcd_q <= bcd_step_d;
          bin_q <= bin_step_d;
          cnt_q <= cnt_q - CntWidth'(1);
          if (cnt_q == CntWidth'(1)) begin
            cnt_q   <= CntWidth'(fd_q);
            state_q <= StTrim;
          end
        end

        StTrim: begin
          if (!keep_q && cnt_q != '0 && trim_digit == 4'd0) begin
            cnt_q <= cnt_q - CntWidth'(1);
          end else if (cnt_q != '0) begin
            state_q <= StDot;
          end else begin
            state_q <= StNewline;
          end
        end

        StDot: begin
          if (slot_free) begin
            ovalid_q <= 1'b1;
            ochar_q  <= CharDot;
            olast_q  <= 1'b0;
            ofin_q   <= fin_q;
            state_q  <= StEmitF;
          end
        end

        // fraction digits sit in the low nine BCD digits
        StEmitF: begin
          if (slot_free) begin
            ovalid_q <= 1'b1;
            ochar_q  <= CharZero + CharWidth'(bcd_q[4*FracDigits-1 -: 4]);
            olast_q  <= 1'b0;
            ofin_q   <= fin_q;
            bcd_q    <= {bcd_q[BcdWidth-5:0], 4'd0};
            cnt_q    <= cnt_q - CntWidth'(1);
            if (cnt_q == CntWidth'(1)) begin
              state_q <= StNewline;
            end
          end
        end

        StNewline: begin
          if (slot_free) begin
            ovalid_q <= 1'b1;
            ochar_q  <= CharNewline;
            olast_q  <= 1'b1;
            ofin_q   <= fin_q;
            state_q  <= StIdle;
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && olast_q |-> ochar_q == CharNewline)
    else $error("line end without newline");

  a_stop_marks_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stopped_q) |-> fin_q)
    else $error("stopped without final line");

  a_stopped_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stopped_q |=> $stable(ticks_q) && state_q == StIdle)
    else $error("tick counted after stop");

  a_conv_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConvI || state_q == StConvF) |-> cnt_q != '0)
    else $error("conversion step count underflow");
`endif

endmodule
